>>> sv/lgs_pkg.sv
package lgs_pkg;

    localparam int ROW_BITS    = 64;
    localparam int MAX_ROWS    = 4096;
    localparam int COUNT_W     = $clog2(MAX_ROWS + 1);
    localparam int IDX_W       = 12;
    localparam int WID_W       = 7;
    localparam int COL_W       = $clog2(ROW_BITS);
    localparam int MIN_WIDTH   = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_PUSH    = 3;
    localparam int PUSH_W      = $clog2(MAX_PUSH + 1);

    typedef logic [ROW_BITS-1:0] row_t;
    typedef logic [WID_W-1:0]    width_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_cells;
        logic                last_row;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]    row_index;
        logic [ROW_BITS-1:0] next_cells;
        logic                last_result;
        logic                error;
    } out_t;

    // Results written into the queue together, item 0 first
    typedef struct packed {
        logic [PUSH_W-1:0]      count;
        out_t [MAX_PUSH-1:0]    items;
    } push_t;

    function automatic row_t col_mask(input width_t w);
        row_t m;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            m[i] = (WID_W'(i) < w);
        end
        return m;
    endfunction

endpackage

>>> sv/lgs_cell_lane.sv
module lgs_cell_lane (
    input  logic [2:0] above_win,
    input  logic [2:0] mid_win,
    input  logic [2:0] below_win,
    output logic       alive
);
    logic [3:0] nsum;

    // Window bits: 0 left, 1 centre, 2 right; the centre cell itself is not counted
    assign nsum = 4'(above_win[0]) + 4'(above_win[1]) + 4'(above_win[2])
                + 4'(mid_win[0]) + 4'(mid_win[2])
                + 4'(below_win[0]) + 4'(below_win[1]) + 4'(below_win[2]);

    assign alive = (nsum == 4'd3) || (mid_win[1] && (nsum == 4'd2));

endmodule

>>> sv/lgs_row_eval.sv
module lgs_row_eval (
    input  lgs_pkg::row_t   above,
    input  lgs_pkg::row_t   mid,
    input  lgs_pkg::row_t   below,
    input  lgs_pkg::width_t width,
    output lgs_pkg::row_t   cells
);
    import lgs_pkg::*;

    width_t            last_w;
    logic [COL_W-1:0]  last_col;
    row_t              lane_alive;

    assign last_w   = width - WID_W'(1);
    assign last_col = last_w[COL_W-1:0];

    for (genvar c = 0; c < ROW_BITS; c++)
    begin : g_lane
        logic [2:0] a_win;
        logic [2:0] m_win;
        logic [2:0] b_win;

        if (c == 0)
        begin : g_left_wrap
            assign a_win[0] = above[last_col];
            assign m_win[0] = mid[last_col];
            assign b_win[0] = below[last_col];
        end
        else
        begin : g_left
            assign a_win[0] = above[c-1];
            assign m_win[0] = mid[c-1];
            assign b_win[0] = below[c-1];
        end

        assign a_win[1] = above[c];
        assign m_win[1] = mid[c];
        assign b_win[1] = below[c];

        if (c == ROW_BITS - 1)
        begin : g_right_wrap
            assign a_win[2] = above[0];
            assign m_win[2] = mid[0];
            assign b_win[2] = below[0];
        end
        else
        begin : g_right
            // wrap to column 0 when this lane is the last column in use
            logic at_edge;
            assign at_edge  = (width == WID_W'(c + 1));
            assign a_win[2] = at_edge ? above[0] : above[c+1];
            assign m_win[2] = at_edge ? mid[0]   : mid[c+1];
            assign b_win[2] = at_edge ? below[0] : below[c+1];
        end

        lgs_cell_lane u_lane (
            .above_win (a_win),
            .mid_win   (m_win),
            .below_win (b_win),
            .alive     (lane_alive[c])
        );
    end

    // Merge the lanes and drop columns beyond the wrap point
    assign cells = lane_alive & col_mask(width);

endmodule

>>> sv/lgs_result_fifo.sv
module lgs_result_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  lgs_pkg::push_t push,
    output logic           space,
    output logic           res_valid,
    input  logic           res_ready,
    output lgs_pkg::out_t  res_data
);
    import lgs_pkg::*;

    out_t              entries_reg [FIFO_DEPTH];
    out_t              entries_next [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;

    assign pop       = res_valid && res_ready;
    assign res_valid = (count_reg != '0);
    assign res_data  = entries_reg[rd_ptr_reg];
    assign space     = (count_reg <= CNT_W'(FIFO_DEPTH - MAX_PUSH));

    for (genvar i = 0; i < FIFO_DEPTH; i++)
    begin : g_entry
        logic [PTR_W-1:0] offset;
        assign offset = PTR_W'(i) - wr_ptr_reg;

        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (PUSH_W'(offset) < push.count)
            begin
                entries_next[i] = push.items[offset];
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FIFO_DEPTH; i++)
        begin
            entries_reg[i] <= entries_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.count == '0) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("result queue count did not drop on a lone pop");
`endif

endmodule

>>> sv/life_generation_step.sv
// Streaming toroidal life step (B3/S23): send the rows of a frame in order,
// marking the final one with last_row; after row k arrives the next generation
// of row k-1 comes out, and the last row releases rows N-2, N-1 and then 0
// (flagged last_result). Each row is worked out combinationally by one lane per
// column, so rows are taken one per clock while the queue has room; results
// leave through a four-entry queue, and a last row, which queues three results,
// holds row_ready low while they drain. grid_width, written on cfg_wdata, sets
// the column wrap point (clamped to 3..64); columns above it read and come out
// as zero. A frame of fewer than three rows, or more than 4096, ends with a
// single result flagged error and last_result. Write grid_width only while
// the block is idle.
module life_generation_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           row_valid,
    output logic           row_ready,
    input  lgs_pkg::in_t   row_data,
    output logic           res_valid,
    input  logic           res_ready,
    output lgs_pkg::out_t  res_data,
    input  logic           cfg_we,
    input  logic [6:0]     cfg_wdata
);
    import lgs_pkg::*;

    width_t              width_reg;
    width_t              width_next;
    row_t                first_row_reg;
    row_t                first_row_next;
    row_t                second_row_reg;
    row_t                second_row_next;
    row_t                older_row_reg;
    row_t                older_row_next;
    row_t                previous_row_reg;
    row_t                previous_row_next;
    logic [COUNT_W-1:0]  rows_seen_reg;
    logic [COUNT_W-1:0]  rows_seen_next;

    logic                accept;
    row_t                row_m;
    row_t                cells_a;
    row_t                cells_b;
    row_t                cells_c;
    logic [COUNT_W-1:0]  k_prev;
    logic                overrun;
    push_t               push;
    out_t                err_item;

    assign accept  = row_valid && row_ready;
    assign row_m   = row_data.row_cells & col_mask(width_reg);
    assign k_prev  = rows_seen_reg - COUNT_W'(1);
    assign overrun = (rows_seen_reg >= COUNT_W'(MAX_ROWS));

    // Row k-1 from rows k-2, k-1, k
    lgs_row_eval u_eval_a (
        .above (older_row_reg),
        .mid   (previous_row_reg),
        .below (row_m),
        .width (width_reg),
        .cells (cells_a)
    );

    // Last row, wrapping down to row 0
    lgs_row_eval u_eval_b (
        .above (previous_row_reg),
        .mid   (row_m),
        .below (first_row_reg),
        .width (width_reg),
        .cells (cells_b)
    );

    // Row 0, wrapping up to the last row
    lgs_row_eval u_eval_c (
        .above (row_m),
        .mid   (first_row_reg),
        .below (second_row_reg),
        .width (width_reg),
        .cells (cells_c)
    );

    always_comb
    begin
        err_item.row_index   = '0;
        err_item.next_cells  = '0;
        err_item.last_result = 1'b1;
        err_item.error       = 1'b1;
    end

    always_comb
    begin
        width_next = width_reg;
        if (cfg_we)
        begin
            priority if (cfg_wdata > WID_W'(ROW_BITS))
                width_next = WID_W'(ROW_BITS);
            else if (cfg_wdata < WID_W'(MIN_WIDTH))
                width_next = WID_W'(MIN_WIDTH);
            else
                width_next = cfg_wdata;
        end
    end

    always_comb
    begin
        first_row_next    = first_row_reg;
        second_row_next   = second_row_reg;
        older_row_next    = older_row_reg;
        previous_row_next = previous_row_reg;
        rows_seen_next    = rows_seen_reg;

        push.count                   = '0;
        push.items                   = '0;
        push.items[0].row_index      = k_prev[IDX_W-1:0];
        push.items[0].next_cells     = cells_a;
        push.items[1].row_index      = rows_seen_reg[IDX_W-1:0];
        push.items[1].next_cells     = cells_b;
        push.items[2].next_cells     = cells_c;
        push.items[2].last_result    = 1'b1;

        if (accept)
        begin
            priority if (overrun || (row_data.last_row && rows_seen_reg < COUNT_W'(2)))
            begin
                // Drop rows past the limit; close a bad frame with one error result
                if (row_data.last_row)
                begin
                    push.count     = PUSH_W'(1);
                    push.items[0]  = err_item;
                    rows_seen_next = '0;
                end
            end
            else if (row_data.last_row)
            begin
                push.count     = PUSH_W'(3);
                rows_seen_next = '0;
            end
            else
            begin
                priority if (rows_seen_reg == COUNT_W'(0))
                    first_row_next = row_m;
                else if (rows_seen_reg == COUNT_W'(1))
                    second_row_next = row_m;
                else
                    push.count = PUSH_W'(1);
                older_row_next    = previous_row_reg;
                previous_row_next = row_m;
                rows_seen_next    = rows_seen_reg + COUNT_W'(1);
            end
        end
    end

    lgs_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (row_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= WID_W'(ROW_BITS);
            first_row_reg    <= '0;
            second_row_reg   <= '0;
            older_row_reg    <= '0;
            previous_row_reg <= '0;
            rows_seen_reg    <= '0;
        end
        else
        begin
            width_reg        <= width_next;
            first_row_reg    <= first_row_next;
            second_row_reg   <= second_row_next;
            older_row_reg    <= older_row_next;
            previous_row_reg <= previous_row_next;
            rows_seen_reg    <= rows_seen_next;
        end
    end

`ifndef SYNTHESIS
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.error) |->
            (res_data.last_result && res_data.next_cells == '0 && res_data.row_index == '0))
        else $error("error result is not a bare closing transaction");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rows_seen_reg <= COUNT_W'(MAX_ROWS))
        else $error("row count ran past its limit");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_data.last_row) |=> (rows_seen_reg == '0))
        else $error("frame did not restart after its last row");
`endif

endmodule

>>> tb/sv/tb_life_generation_step.sv
module tb_life_generation_step;
    import lgs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 80;
    localparam int REPORT_LIMIT   = 10;

    localparam out_t FRAME_ERROR = '{row_index: '0, next_cells: '0,
                                     last_result: 1'b1, error: 1'b1};

    typedef struct {
        in_t  item;
        bit   typed;
        out_t want;
    } stimulus_row_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   row_valid;
    logic   row_ready;
    in_t    row_data;
    logic   res_valid;
    logic   res_ready;
    out_t   res_data;
    logic   cfg_we;
    logic [6:0] cfg_wdata;

    always #1 clk = ~clk;

    life_generation_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row_data  (row_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Own copy of the grid state and the width register
    width_t width_reg = 7'd64;
    row_t   frame_row0 = '0;
    row_t   frame_row1 = '0;
    row_t   row_km2 = '0;
    row_t   row_km1 = '0;
    int     rows_in_frame = 0;

    out_t   pending_rows[$];
    int     mismatch_count = 0;
    int     quiet_cycles = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     frame_left = 0;
    bit     pressure_on = 1'b0;
    bit     pressure_taken = 1'b0;

    // Directed frames: short frames, overcrowding, a blinker across the column
    // wrap, a glider, edge columns and stripes; the last frame is left open.
    stimulus_row_t directed_rows [21] = '{
        '{'{64'h0, 1'b1}, 1'b1, FRAME_ERROR},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1, FRAME_ERROR},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b0, '0},
        '{'{64'h0, 1'b0}, 1'b0, '0},
        '{'{64'h8000_0000_0000_0003, 1'b0}, 1'b0, '0},
        '{'{64'h0, 1'b0}, 1'b0, '0},
        '{'{64'h0, 1'b0}, 1'b0, '0},
        '{'{64'h0, 1'b1}, 1'b0, '0},
        '{'{64'h0000_0000_0000_0002, 1'b0}, 1'b0, '0},
        '{'{64'h0000_0000_0000_0004, 1'b0}, 1'b0, '0},
        '{'{64'h0000_0000_0000_0007, 1'b0}, 1'b0, '0},
        '{'{64'h8000_0000_0000_0001, 1'b0}, 1'b0, '0},
        '{'{64'hFFFF_FFFF_FFFF_FFFE, 1'b1}, 1'b0, '0},
        '{'{64'hAAAA_AAAA_AAAA_AAAA, 1'b0}, 1'b0, '0},
        '{'{64'h5555_5555_5555_5555, 1'b0}, 1'b0, '0},
        '{'{64'hFFFF_0000_FFFF_0000, 1'b1}, 1'b0, '0},
        '{'{64'h0, 1'b0}, 1'b0, '0},
        '{'{64'h0000_0000_0000_0001, 1'b0}, 1'b0, '0}
    };

    function automatic row_t life_advance(input row_t above, input row_t mid,
                                          input row_t below, input int w);
        row_t res;
        int   l;
        int   r;
        int   sum;
        res = '0;
        for (int c = 0; c < w; c++)
        begin
            l = (c == 0) ? w - 1 : c - 1;
            r = (c + 1 == w) ? 0 : c + 1;
            sum = $countones({above[l], above[c], above[r], mid[l], mid[r],
                              below[l], below[c], below[r]});
            if (sum == 3 || (mid[c] && sum == 2))
                res[c] = 1'b1;
        end
        return res;
    endfunction

    // Advance the grid state by one row and return the rows it completes
    function automatic int life_predict(input in_t item, output out_t res [3]);
        int   w;
        row_t row;
        int   n;
        w = int'(width_reg);
        if (w > ROW_BITS)
            w = ROW_BITS;
        if (w < MIN_WIDTH)
            w = MIN_WIDTH;
        row = item.row_cells & ((w >= ROW_BITS) ? '1 : ((row_t'(1) << w) - row_t'(1)));
        n = 0;
        if (rows_in_frame >= MAX_ROWS || (item.last_row && rows_in_frame < 2))
        begin
            if (item.last_row)
            begin
                res[0] = FRAME_ERROR;
                rows_in_frame = 0;
                return 1;
            end
            return 0;
        end
        if (rows_in_frame == 0)
            frame_row0 = row;
        else if (rows_in_frame == 1)
            frame_row1 = row;
        else
        begin
            res[n] = '{IDX_W'(rows_in_frame - 1), life_advance(row_km2, row_km1, row, w),
                       1'b0, 1'b0};
            n++;
        end
        if (item.last_row)
        begin
            res[n] = '{IDX_W'(rows_in_frame), life_advance(row_km1, row, frame_row0, w),
                       1'b0, 1'b0};
            res[n + 1] = '{'0, life_advance(row, frame_row0, frame_row1, w), 1'b1, 1'b0};
            rows_in_frame = 0;
            return n + 2;
        end
        row_km2 = row_km1;
        row_km1 = row;
        rows_in_frame++;
        return n;
    endfunction

    function automatic row_t random_cells();
        row_t a;
        row_t b;
        row_t c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0, 1:    return a;
            2, 3:    return a & b & c;
            4:       return a & b;
            5:       return a | b;
            6:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic send_row(input in_t item, input bit typed, input out_t want);
        out_t res [3];
        int   n;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            row_valid <= 1'b0;
            @(negedge clk);
        end
        row_valid <= 1'b1;
        row_data  <= item;
        @(posedge clk);
        while (!row_ready)
            @(posedge clk);
        n = life_predict(item, res);
        if (typed)
            pending_rows.push_back(want);
        else
            for (int i = 0; i < n; i++)
                pending_rows.push_back(res[i]);
    endtask

    // Drop valid, drain the results, then let the pipeline empty out
    task automatic settle();
        @(negedge clk);
        row_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input width_t w, input int idle, input int stall,
                             input int count);
        in_t item;
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
        width_reg = w;
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            if (frame_left == 0)
            begin
                case ($urandom_range(0, 19))
                    0:       frame_left = 1;
                    1:       frame_left = 2;
                    default: frame_left = $urandom_range(3, 10);
                endcase
            end
            item.row_cells = random_cells();
            // cut a frame short now and then
            item.last_row  = (frame_left == 1) || ($urandom_range(0, 49) == 0);
            frame_left     = item.last_row ? 0 : frame_left - 1;
            send_row(item, 1'b0, '0);
        end
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_on && !pressure_taken)
            begin
                hold_left      = HOLD_CYCLES;
                pressure_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                res_ready <= 1'b0;
                hold_left--;
            end
            else
                res_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input out_t want, input out_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s: want idx %0d cells %h last %b err %b, got %0d %h %b %b",
                     what, want.row_index, want.next_cells, want.last_result, want.error,
                     got.row_index, got.next_cells, got.last_result, got.error);
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if ((row_valid && row_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("life_generation_step verification failed");
                $finish;
            end
            if (res_valid && res_ready)
            begin
                if (pending_rows.size() == 0)
                    report_mismatch("unexpected transaction", '0, res_data);
                else
                begin
                    want = pending_rows.pop_front();
                    if (res_data.row_index !== want.row_index
                        || res_data.next_cells !== want.next_cells
                        || res_data.last_result !== want.last_result
                        || res_data.error !== want.error)
                        report_mismatch("result mismatch", want, res_data);
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        row_valid = 1'b0;
        row_data  = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_row(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // width changes land mid-frame where a phase leaves one open
        run_phase(7'd3,   0,  0,  40);
        run_phase(7'd0,   79, 0,  35);
        run_phase(7'd127, 0,  79, 35);
        // start the long hold once drained, so it lands on the next phase's rows
        settle();
        pressure_on = 1'b1;
        run_phase(7'd65,  16, 16, 40);
        run_phase(7'd2,   0,  0,  35);
        run_phase(7'd64,  0,  0,  15);

        settle();
        if (mismatch_count == 0 && pending_rows.size() == 0)
            $display("life_generation_step verification clean");
        else
            $display("life_generation_step verification failed");
        $finish;
    end

endmodule
